// File: hdl/svcm_pkg.sv
// shared types, codes and pitch table of the voice command manager
package svcm_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = 5;
    localparam int VOL_W = 8;
    localparam int LVL_W = 3;
    localparam int PROD_W = VOL_W + LVL_W;
    localparam int FNS_W = 10;
    localparam int PITCH_W = 15;
    localparam int SLOT_W = 4;

    localparam logic [LVL_W-1:0] LEVEL_MAX = 3'd7;

    // divide by seven: multiply by 73, shift by 9, then one correction step
    localparam int RECIP_MUL = 73;
    localparam int RECIP_SHIFT = 9;
    localparam int RECIP_W = PROD_W + 7;

    localparam logic [1:0] MODE_NOTE  = 2'd0;
    localparam logic [1:0] MODE_LEVEL = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    localparam logic [1:0] CMD_OFF   = 2'd0;
    localparam logic [1:0] CMD_ON    = 2'd1;
    localparam logic [1:0] CMD_NOISE = 2'd2;
    localparam logic [1:0] CMD_LEVEL = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NOTE,
        KIND_LEVEL,
        KIND_STOP
    } item_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic scan_load;
        logic idx_inc;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        item_kind_t kind;
        logic       scan_empty;
        logic       scan_emit;
        logic       res_last;
        logic       out_free;
    } dp_status_t;

    function automatic logic [FNS_W-1:0] fns_value(input logic [3:0] idx);
        logic [FNS_W-1:0] val;
        case (idx)
            4'd1:    val = 10'h03D;
            4'd2:    val = 10'h07D;
            4'd3:    val = 10'h0C2;
            4'd4:    val = 10'h10A;
            4'd5:    val = 10'h157;
            4'd6:    val = 10'h1A8;
            4'd7:    val = 10'h1FE;
            4'd8:    val = 10'h25A;
            4'd9:    val = 10'h2BA;
            4'd10:   val = 10'h321;
            4'd11:   val = 10'h38D;
            default: val = 10'h000;
        endcase
        return val;
    endfunction

endpackage

// File: hdl/svcm_ctrl.sv
// sequencing state machine: item intake, voice sweep and result hand-off
module svcm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  svcm_pkg::dp_status_t  status,
    output svcm_pkg::ctl_cmd_t    cmd
);

    svcm_pkg::ctrl_state_t state_reg;
    svcm_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svcm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            svcm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (status.kind)
                        svcm_pkg::KIND_NOTE:  state_next = svcm_pkg::ST_EMIT;
                        svcm_pkg::KIND_LEVEL: state_next = svcm_pkg::ST_SCAN;
                        svcm_pkg::KIND_STOP:  state_next = svcm_pkg::ST_SCAN;
                        default:              state_next = svcm_pkg::ST_IDLE;
                    endcase
                end
            end
            svcm_pkg::ST_SCAN:
            begin
                if (status.scan_empty)
                begin
                    state_next = svcm_pkg::ST_IDLE;
                end
                else if (status.scan_emit)
                begin
                    cmd.scan_load = 1'b1;
                    state_next = svcm_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            svcm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.res_last)
                    begin
                        state_next = svcm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next = svcm_pkg::ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = svcm_pkg::ST_IDLE;
            end
        endcase
    end

    assign item_stall = (state_reg != svcm_pkg::ST_IDLE);

endmodule

// File: hdl/svcm_datapath.sv
// voice state, command builder, level scaling and output register
module svcm_datapath #(
    parameter int VOICE_COUNT = 32,
    parameter int WAVE_COUNT = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  svcm_pkg::ctl_cmd_t          cmd,
    output svcm_pkg::dp_status_t        status,
    input  logic [1:0]                  mode,
    input  logic [7:0]                  channel,
    input  logic signed [7:0]           semitone,
    input  logic signed [7:0]           octave,
    input  logic [7:0]                  wave_number,
    input  logic [7:0]                  volume,
    input  logic signed [7:0]           new_level,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  command,
    output logic [4:0]                  voice,
    output logic [14:0]                 pitch_word,
    output logic [3:0]                  wave_slot,
    output logic [7:0]                  out_level,
    output logic                        last
);

    localparam int DEPTH = svcm_pkg::DEPTH;
    localparam int IDX_W = svcm_pkg::IDX_W;
    localparam int VOL_W = svcm_pkg::VOL_W;
    localparam int LVL_W = svcm_pkg::LVL_W;
    localparam int PROD_W = svcm_pkg::PROD_W;
    localparam int RECIP_W = svcm_pkg::RECIP_W;
    localparam int VOICES = (VOICE_COUNT < DEPTH) ? VOICE_COUNT : DEPTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    // voice state
    logic [VOL_W-1:0] volume_reg [DEPTH];
    logic [DEPTH-1:0] active_reg;
    logic [LVL_W-1:0] master_reg;

    // sweep and pending result
    logic [IDX_W-1:0]                  idx_reg;
    logic                              sweep_stop_reg;
    logic [1:0]                        res_cmd_reg;
    logic [IDX_W-1:0]                  res_voice_reg;
    logic [svcm_pkg::PITCH_W-1:0]      res_pitch_reg;
    logic [svcm_pkg::SLOT_W-1:0]       res_wave_reg;
    logic                              res_last_reg;
    logic [PROD_W-1:0]                 prod_reg;

    // output register
    logic                              result_valid_reg;
    logic [1:0]                        command_reg;
    logic [IDX_W-1:0]                  voice_reg;
    logic [svcm_pkg::PITCH_W-1:0]      pitch_word_reg;
    logic [svcm_pkg::SLOT_W-1:0]       wave_slot_reg;
    logic [VOL_W-1:0]                  out_level_reg;
    logic                              last_reg;

    svcm_pkg::item_kind_t              kind;
    logic [IDX_W-1:0]                  ch_idx;
    logic [3:0]                        semi_idx;
    logic [3:0]                        oct_nib;
    logic [svcm_pkg::PITCH_W-1:0]      note_pitch;
    logic                              is_noise;
    logic                              key_off;
    logic [LVL_W-1:0]                  level_clamped;
    logic [PROD_W-1:0]                 note_prod;
    logic [VOL_W-1:0]                  scan_vol;
    logic [PROD_W-1:0]                 scan_prod;
    logic [DEPTH-1:0]                  mask_from;
    logic [DEPTH-1:0]                  pending;
    logic [DEPTH-1:0]                  ahead;
    logic [RECIP_W-1:0]                recip_prod;
    logic [VOL_W-1:0]                  q0;
    logic [PROD_W-1:0]                 seven_q0;
    logic [PROD_W-1:0]                 rem;
    logic [VOL_W-1:0]                  quotient;
    logic                              out_free;

    // item decode
    always_comb
    begin
        case (mode)
            svcm_pkg::MODE_NOTE:
                kind = (channel < 8'(VOICES)) ? svcm_pkg::KIND_NOTE : svcm_pkg::KIND_NONE;
            svcm_pkg::MODE_LEVEL: kind = svcm_pkg::KIND_LEVEL;
            svcm_pkg::MODE_STOP:  kind = svcm_pkg::KIND_STOP;
            default:              kind = svcm_pkg::KIND_NONE;
        endcase
    end

    assign ch_idx = channel[IDX_W-1:0];
    assign key_off = semitone[7];
    assign is_noise = (wave_number >= 8'(WAVE_COUNT));
    assign semi_idx = (semitone > 8'sd11) ? 4'd11 : semitone[3:0];

    always_comb
    begin
        if (octave < -8'sd8)
        begin
            oct_nib = 4'b1000;
        end
        else if (octave > 8'sd7)
        begin
            oct_nib = 4'b0111;
        end
        else
        begin
            oct_nib = octave[3:0];
        end
    end

    assign note_pitch = {oct_nib, 1'b0, svcm_pkg::fns_value(semi_idx)};

    always_comb
    begin
        if (new_level[7])
        begin
            level_clamped = '0;
        end
        else if (new_level > 8'sd7)
        begin
            level_clamped = svcm_pkg::LEVEL_MAX;
        end
        else
        begin
            level_clamped = new_level[LVL_W-1:0];
        end
    end

    assign note_prod = {3'b000, volume} * {8'b0, master_reg};

    // sweep lookahead
    assign scan_vol = volume_reg[idx_reg];
    assign scan_prod = {3'b000, scan_vol} * {8'b0, master_reg};
    assign mask_from = {DEPTH{1'b1}} << idx_reg;
    assign pending = active_reg & mask_from;
    assign ahead = active_reg & (mask_from << 1);

    // level / 7 with one correction step
    assign recip_prod = {7'b0, prod_reg} * RECIP_W'(svcm_pkg::RECIP_MUL);
    assign q0 = recip_prod[svcm_pkg::RECIP_SHIFT +: VOL_W];
    assign seven_q0 = {3'b000, q0} * 11'd7;
    assign rem = prod_reg - seven_q0;
    assign quotient = (rem >= 11'd7) ? q0 + 8'd1 : q0;

    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            master_reg <= svcm_pkg::LEVEL_MAX;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                case (kind)
                    svcm_pkg::KIND_NOTE:  active_reg[ch_idx] <= !key_off;
                    svcm_pkg::KIND_LEVEL: master_reg <= level_clamped;
                    svcm_pkg::KIND_STOP:  active_reg <= '0;
                    default:              active_reg <= active_reg;
                endcase
            end
            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            idx_reg <= '0;
            sweep_stop_reg <= (kind == svcm_pkg::KIND_STOP);
            if (kind == svcm_pkg::KIND_NOTE)
            begin
                res_voice_reg <= ch_idx;
                res_last_reg <= 1'b1;
                if (key_off)
                begin
                    res_cmd_reg <= svcm_pkg::CMD_OFF;
                    res_pitch_reg <= '0;
                    res_wave_reg <= '0;
                    prod_reg <= '0;
                end
                else
                begin
                    volume_reg[ch_idx] <= volume;
                    res_cmd_reg <= is_noise ? svcm_pkg::CMD_NOISE : svcm_pkg::CMD_ON;
                    res_pitch_reg <= is_noise ? '0 : note_pitch;
                    res_wave_reg <= is_noise ? '0 : wave_number[3:0];
                    prod_reg <= note_prod;
                end
            end
        end
        else
        begin
            if (cmd.scan_load)
            begin
                res_cmd_reg <= sweep_stop_reg ? svcm_pkg::CMD_OFF : svcm_pkg::CMD_LEVEL;
                res_voice_reg <= idx_reg;
                res_pitch_reg <= '0;
                res_wave_reg <= '0;
                prod_reg <= sweep_stop_reg ? '0 : scan_prod;
                res_last_reg <= sweep_stop_reg ? (idx_reg == LAST_IDX) : (ahead == '0);
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (cmd.emit)
        begin
            command_reg <= res_cmd_reg;
            voice_reg <= res_voice_reg;
            pitch_word_reg <= res_pitch_reg;
            wave_slot_reg <= res_wave_reg;
            out_level_reg <= quotient;
            last_reg <= res_last_reg;
        end
    end

    assign status.kind = kind;
    assign status.scan_emit = sweep_stop_reg || active_reg[idx_reg];
    assign status.scan_empty = !sweep_stop_reg && (pending == '0);
    assign status.res_last = res_last_reg;
    assign status.out_free = out_free;

    assign result_valid = result_valid_reg;
    assign command = command_reg;
    assign voice = voice_reg;
    assign pitch_word = pitch_word_reg;
    assign wave_slot = wave_slot_reg;
    assign out_level = out_level_reg;
    assign last = last_reg;

`ifndef SYNTHESIS
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item && kind == svcm_pkg::KIND_STOP |=> active_reg == '0)
        else $error("stop left a voice active");

    a_div_corr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> rem < 11'd14)
        else $error("level divide needs more than one correction");

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && command_reg == svcm_pkg::CMD_OFF
        |-> out_level_reg == '0 && pitch_word_reg == '0 && wave_slot_reg == '0)
        else $error("key off carries a level or pitch");
`endif

endmodule

// File: hdl/synth_voice_command_manager.sv
// top level of the voice command manager
//
//  channel  valid         stall         payload
//  item     item_valid    item_stall    mode channel semitone octave wave_number volume new_level
//  result   result_valid  result_stall  command voice pitch_word wave_slot out_level last
//
// one item at a time; a note event is loaded into the pending result, then emitted to the output register
// a level change sweeps the voice index up to the highest active voice and emits one result per
// active voice, or none when no voice is active; a stop emits a key off for every voice
// the sweep counter steps through the voices in the scan state, and each result leaves through the emit state
// reset clears every active flag and sets the master level to seven
// a stalled result holds in the output register; the next item is taken meanwhile
module synth_voice_command_manager #(
    parameter int VOICE_COUNT = 32,
    parameter int WAVE_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        mode,
    input  logic [7:0]        channel,
    input  logic signed [7:0] semitone,
    input  logic signed [7:0] octave,
    input  logic [7:0]        wave_number,
    input  logic [7:0]        volume,
    input  logic signed [7:0] new_level,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [1:0]        command,
    output logic [4:0]        voice,
    output logic [14:0]       pitch_word,
    output logic [3:0]        wave_slot,
    output logic [7:0]        out_level,
    output logic              last
);

    svcm_pkg::ctl_cmd_t   cmd;
    svcm_pkg::dp_status_t status;

    svcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    svcm_datapath #(
        .VOICE_COUNT (VOICE_COUNT),
        .WAVE_COUNT  (WAVE_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .channel      (channel),
        .semitone     (semitone),
        .octave       (octave),
        .wave_number  (wave_number),
        .volume       (volume),
        .new_level    (new_level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .command      (command),
        .voice        (voice),
        .pitch_word   (pitch_word),
        .wave_slot    (wave_slot),
        .out_level    (out_level),
        .last         (last)
    );

endmodule
